FILE: design/pblsc_pkg.sv
`default_nettype none

package pblsc_pkg;

    // Defaults for the top-level parameters
    localparam int SLOTS_DEF       = 12;
    localparam int WINDOWS_DEF     = 4;
    localparam int SLOT_OFFSET_DEF = 64;
    localparam int BLOCK_BYTES_DEF = 8192;

    // Fixed field widths
    localparam int WINDOW_W = 2;
    localparam int BANK_W   = 6;
    localparam int SLOT_O_W = 4;
    localparam int REMAP_W  = 7;
    localparam int FILL_W   = 19;
    localparam int STAMP_W  = 32;

    // One slot entry as held in the slot memory
    typedef struct packed {
        logic [BANK_W-1:0]  bank;
        logic [STAMP_W-1:0] stamp;
    } t_ent;

    // Registered read return; vld low means the slot has never been filled
    typedef struct packed {
        logic               vld;
        logic [BANK_W-1:0]  bank;
        logic [STAMP_W-1:0] stamp;
    } t_mem_rd;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_SCAN  = 5'b00010,
        ST_DRAIN = 5'b00100,
        ST_UPD   = 5'b01000,
        ST_DONE  = 5'b10000
    } t_state;

endpackage

`default_nettype wire

FILE: design/pblsc_mem.sv
`default_nettype none

module pblsc_mem
    import pblsc_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(SLOTS)-1:0] i_rd_addr,
    output t_mem_rd                       o_rd,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(SLOTS)-1:0] i_wr_addr,
    input  wire t_ent                     i_wr
);

    t_ent             r_mem [SLOTS];
    logic [SLOTS-1:0] r_ent_vld;
    t_ent             r_rd_ent;
    logic             r_rd_vld;

    // Per-entry written flags; an unwritten slot reads as empty with stamp 0
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld <= r_ent_vld[i_rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr;
        end
        if (i_rd_en) begin
            r_rd_ent <= r_mem[i_rd_addr];
        end
    end

    always_comb begin
        o_rd.vld   = r_rd_vld;
        o_rd.bank  = r_rd_vld ? r_rd_ent.bank  : '0;
        o_rd.stamp = r_rd_vld ? r_rd_ent.stamp : '0;
    end

endmodule

`default_nettype wire

FILE: design/pblsc_ctrl.sv
`default_nettype none

module pblsc_ctrl
    import pblsc_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int WINDOWS = WINDOWS_DEF
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic [WINDOW_W-1:0]      i_window,
    input  wire logic [BANK_W-1:0]        i_bank,
    output logic                          o_rd_en,
    output logic [$clog2(SLOTS)-1:0]      o_rd_addr,
    input  wire t_mem_rd                  i_rd,
    output logic                          o_wr_en,
    output logic [$clog2(SLOTS)-1:0]      o_wr_addr,
    output t_ent                          o_wr,
    output logic                          o_done,
    input  wire logic                     i_out_free,
    output logic [$clog2(SLOTS)-1:0]      o_slot,
    output logic                          o_hit,
    output logic [BANK_W-1:0]             o_bank
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int WIN_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1;
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SLOTS - 1);

    t_state               r_state, n_state;
    logic [SLOT_W-1:0]    r_idx;
    logic                 r_cmp_vld;
    logic [SLOT_W-1:0]    r_cmp_idx;
    logic [WIN_W-1:0]     r_win;
    logic [BANK_W-1:0]    r_bank;
    logic                 r_hit;
    logic [SLOT_W-1:0]    r_hit_idx;
    logic                 r_unp_found;
    logic [SLOT_W-1:0]    r_unp_idx;
    logic [STAMP_W-1:0]   r_unp_stamp;
    logic [SLOT_W-1:0]    r_all_idx;
    logic [STAMP_W-1:0]   r_all_stamp;
    logic [STAMP_W-1:0]   r_use_clk;
    logic [SLOT_W-1:0]    r_win_slot [WINDOWS];
    logic [WINDOWS-1:0]   r_win_used;
    logic [SLOT_W-1:0]    r_chosen;

    logic                 win_ok;
    logic                 pinned;
    logic                 is_hit;
    logic                 take_unp;
    logic                 take_all;
    logic [SLOT_W-1:0]    chosen;
    logic [STAMP_W-1:0]   next_stamp;

    assign win_ok = (32'(i_window) < 32'(WINDOWS));

    // Slot under compare is pinned if any other live window points at it
    always_comb begin
        pinned = 1'b0;
        for (int w = 0; w < WINDOWS; w++) begin
            if (w != int'(r_win) && r_win_used[w] && r_win_slot[w] == r_cmp_idx) begin
                pinned = 1'b1;
            end
        end
    end

    assign is_hit   = r_cmp_vld && !r_hit && i_rd.vld && (i_rd.bank == r_bank);
    assign take_unp = r_cmp_vld && !pinned && (!r_unp_found || i_rd.stamp < r_unp_stamp);
    assign take_all = r_cmp_vld && ((r_cmp_idx == '0) || i_rd.stamp < r_all_stamp);

    assign chosen     = r_hit ? r_hit_idx : (r_unp_found ? r_unp_idx : r_all_idx);
    assign next_stamp = r_use_clk + STAMP_W'(1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (i_in_valid && win_ok) n_state = ST_SCAN;
            ST_SCAN:  if (r_idx == LAST_SLOT) n_state = ST_DRAIN;
            ST_DRAIN: n_state = ST_UPD;
            ST_UPD:   n_state = ST_DONE;
            ST_DONE:  if (i_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cmp_vld   <= 1'b0;
            r_hit       <= 1'b0;
            r_unp_found <= 1'b0;
            r_use_clk   <= '0;
            r_win_used  <= '0;
        end else begin
            r_state   <= n_state;
            r_cmp_vld <= (r_state == ST_SCAN);
            if (r_state == ST_IDLE) begin
                r_hit       <= 1'b0;
                r_unp_found <= 1'b0;
            end else begin
                if (is_hit)   r_hit       <= 1'b1;
                if (take_unp) r_unp_found <= 1'b1;
            end
            if (r_state == ST_UPD) begin
                r_use_clk         <= next_stamp;
                r_win_used[r_win] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_idx  <= '0;
            r_win  <= WIN_W'(i_window);
            r_bank <= i_bank;
        end else if (r_state == ST_SCAN) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        r_cmp_idx <= r_idx;
        if (is_hit) r_hit_idx <= r_cmp_idx;
        if (take_unp) begin
            r_unp_idx   <= r_cmp_idx;
            r_unp_stamp <= i_rd.stamp;
        end
        if (take_all) begin
            r_all_idx   <= r_cmp_idx;
            r_all_stamp <= i_rd.stamp;
        end
        if (r_state == ST_UPD) begin
            r_win_slot[r_win] <= chosen;
            r_chosen          <= chosen;
        end
    end

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_rd_en    = (r_state == ST_SCAN);
    assign o_rd_addr  = r_idx;
    assign o_wr_en    = (r_state == ST_UPD);
    assign o_wr_addr  = chosen;
    assign o_wr.bank  = r_bank;
    assign o_wr.stamp = next_stamp;
    assign o_done     = (r_state == ST_DONE);
    assign o_slot     = r_chosen;
    assign o_hit      = r_hit;
    assign o_bank     = r_bank;

endmodule

`default_nettype wire

FILE: design/pinned_lru_bank_slot_cache.sv
// Flow: an accepted request passes ST_SCAN, ST_DRAIN, ST_UPD and ST_DONE; the result
// is loaded into the output register as ST_DONE is left. A new request is taken only in
// ST_IDLE, after the last one has left ST_DONE; the victim scan reads the slot memory
// one slot per cycle. A request for a window at or above WINDOWS is accepted and gives no result.
// Reset (i_rst_n low, synchronous): all slots empty with stamp 0, no window mapped,
// use clock 0, output empty. No clearing pass; the block accepts at once.
`default_nettype none

module pinned_lru_bank_slot_cache
    import pblsc_pkg::*;
#(
    parameter int SLOTS       = SLOTS_DEF,
    parameter int WINDOWS     = WINDOWS_DEF,
    parameter int SLOT_OFFSET = SLOT_OFFSET_DEF,
    parameter int BLOCK_BYTES = BLOCK_BYTES_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [1:0] window, [7:2] bank
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [3:0] slot, [10:4] remap_value,
                                             // [29:11] fill_address, [31:30] zero
    output logic             m_axis_tuser    // [0] hit
);

    localparam int SLOT_W = $clog2(SLOTS);

    // Request fields
    logic [WINDOW_W-1:0] in_window;
    logic [BANK_W-1:0]   in_bank;

    assign in_window = s_axis_tdata[WINDOW_W-1:0];
    assign in_bank   = s_axis_tdata[WINDOW_W +: BANK_W];

    // Slot memory port signals
    logic                rd_en;
    logic [SLOT_W-1:0]   rd_addr;
    t_mem_rd             rd;
    logic                wr_en;
    logic [SLOT_W-1:0]   wr_addr;
    t_ent                wr;

    // Sequencer result
    logic                done;
    logic                out_free;
    logic [SLOT_W-1:0]   res_slot;
    logic                res_hit;
    logic [BANK_W-1:0]   res_bank;

    // Output register: the sequencer may start the next transaction while a
    // result is still waiting here, and only stalls at its final state.
    logic                r_out_vld;
    logic [SLOT_O_W-1:0] r_out_slot;
    logic                r_out_hit;
    logic [REMAP_W-1:0]  r_out_remap;
    logic [FILL_W-1:0]   r_out_fill;

    // Slot bank and stamp per entry, read back one slot per cycle
    pblsc_mem #(
        .SLOTS (SLOTS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd      (rd),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr      (wr)
    );

    // Scan for hit, unpinned LRU victim and overall LRU fallback, then update
    pblsc_ctrl #(
        .SLOTS   (SLOTS),
        .WINDOWS (WINDOWS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_window   (in_window),
        .i_bank     (in_bank),
        .o_rd_en    (rd_en),
        .o_rd_addr  (rd_addr),
        .i_rd       (rd),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_wr       (wr),
        .o_done     (done),
        .i_out_free (out_free),
        .o_slot     (res_slot),
        .o_hit      (res_hit),
        .o_bank     (res_bank)
    );

    assign out_free = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= done;
        end
    end

    // Remap value and fill address are formed on load; both wrap to field width
    always_ff @(posedge i_clk) begin
        if (done && out_free) begin
            r_out_slot  <= SLOT_O_W'(res_slot);
            r_out_hit   <= res_hit;
            r_out_remap <= REMAP_W'(32'(SLOT_OFFSET) + 32'(res_slot));
            r_out_fill  <= FILL_W'(32'(res_bank) * 32'(BLOCK_BYTES));
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {2'b00, r_out_fill, r_out_remap, r_out_slot};
    assign m_axis_tuser  = r_out_hit;

endmodule

`default_nettype wire
